// ----- rtl/pdr_pkg.sv -----
// Shared types and constants of the PCM downmix resampler.
package pdr_pkg;

  localparam int unsigned MAX_CHANNELS      = 16;
  localparam int unsigned MAX_OUTPUT_FRAMES = 2880;
  localparam int unsigned OUTPUT_RATE       = 48000;
  localparam int unsigned RESULT_LIMIT      = 8;
  localparam int unsigned RATE_LOW          = 8000;
  localparam int unsigned RATE_HIGH         = 192000;

  localparam logic [1:0] FMT_FLOAT32 = 2'd0;
  localparam logic [1:0] FMT_PCM16   = 2'd1;
  localparam logic [1:0] FMT_PCM24   = 2'd2;
  localparam logic [1:0] FMT_PCM32   = 2'd3;

  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_RATE     = 2'd2;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam int unsigned DIV_NUM_W = 52;
  localparam int unsigned DIV_DEN_W = 29;
  localparam int unsigned DIV_CNT_W = 6;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef struct packed {
    logic [1:0]  sample_format;
    logic [4:0]  channels;
    logic [17:0] rate;
  } pdr_cfg_t;

  typedef struct packed {
    logic               command;
    logic [13:0]        frame_count;
    logic               silent;
    logic signed [24:0] sample;
  } pdr_entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } pdr_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } pdr_div_rsp_t;

endpackage

// ----- rtl/pdr_in_if.sv -----
// Input channel: headers and channel samples.
interface pdr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [13:0] frame_count;
  logic        silent;
  logic [31:0] sample_word;

  modport source (output valid, command, frame_count, silent, sample_word, input ready);
  modport sink (input valid, command, frame_count, silent, sample_word, output ready);
endinterface

// ----- rtl/pdr_out_if.sv -----
// Result channel: stereo Q1.23 frames and status.
interface pdr_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] left_out;
  logic signed [23:0] right_out;
  logic               last_frame;
  logic               status;

  modport source (output valid, left_out, right_out, last_frame, status, input ready);
  modport sink (input valid, left_out, right_out, last_frame, status, output ready);
endinterface

// ----- rtl/pcm_downmix_resampler_unit.sv -----
// Top level of the PCM downmix resampler: configuration registers and wiring.
// Items enter a four-beat queue at one per cycle while it has room; the back end
// then takes one queued beat at a time. A frame-closing sample also goes through
// the two peak divisions when more than two channels are configured and the mixed
// peak exceeds full scale, then through its output frames and the wait for each
// result to be taken. A header runs a division in the shared bit-serial divider.
// The rate register value is saturated to 8000..192000 Hz and the channel count
// to 1..16.
module pcm_downmix_resampler_unit
  import pdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pdr_in_if.sink      in_ch,
  pdr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  logic [1:0]   fmt_r;
  logic [4:0]   chans_r;
  logic [17:0]  rate_r;
  pdr_cfg_t     cfg;
  logic         q_empty;
  logic         q_pop;
  pdr_entry_t   head;
  pdr_div_req_t div_req;
  pdr_div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_PCM16;
      chans_r <= 5'd2;
      rate_r  <= 18'(OUTPUT_RATE);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT:   fmt_r   <= cfg_data[1:0];
        REG_CHANNELS: chans_r <= cfg_data[4:0];
        REG_RATE:     rate_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.sample_format = fmt_r;
    if (chans_r == 5'd0) cfg.channels = 5'd1;
    else if (chans_r > 5'(MAX_CHANNELS)) cfg.channels = 5'(MAX_CHANNELS);
    else cfg.channels = chans_r;
    if (rate_r < 18'(RATE_LOW)) cfg.rate = 18'(RATE_LOW);
    else if (rate_r > 18'(RATE_HIGH)) cfg.rate = 18'(RATE_HIGH);
    else cfg.rate = rate_r;
  end

  pdr_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .in_ch (in_ch),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (head)
  );

  pdr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pdr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .head    (head),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

endmodule

// ----- rtl/pdr_front.sv -----
// Front end: sample decoding and the beat queue toward the back end.
module pdr_front
  import pdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pdr_cfg_t    cfg,
  pdr_in_if.sink      in_ch,
  input  logic        pop,
  output logic        empty,
  output pdr_entry_t  head
);

  pdr_entry_t         q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W:0]    count_r;
  logic               push;
  logic               do_pop;
  pdr_entry_t         entry;

  function automatic logic signed [24:0] decode(input logic [1:0] fmt, input logic [31:0] v);
    logic [7:0]  e;
    logic [22:0] m;
    logic [4:0]  sh;
    logic [25:0] mag;
    logic [25:0] rnd;
    begin
      e   = v[30:23];
      m   = v[22:0];
      sh  = 5'd0;
      mag = '0;
      rnd = '0;
      case (fmt)
        FMT_PCM16: decode = {v[15], v[15:0], 8'h00};
        FMT_PCM24: decode = {v[23], v[23:0]};
        FMT_PCM32: decode = {v[31], v[31:8]};
        default: begin
          if (e == 8'hFF && m != 23'd0) begin
            mag = '0;
          end else if (e >= 8'd127) begin
            mag = 26'h0800000;
          end else if (e == 8'd0 || e < 8'd102) begin
            mag = '0;
          end else begin
            sh  = 5'(8'd127 - e);
            rnd = 26'd1 << (sh - 5'd1);
            mag = ({2'b00, 1'b1, m} + rnd) >> sh;
          end
          decode = v[31] ? -$signed(mag[24:0]) : $signed(mag[24:0]);
        end
      endcase
    end
  endfunction

  assign in_ch.ready = (count_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign empty       = (count_r == '0);
  assign do_pop      = pop && !empty;
  assign head        = q_r[rd_ptr_r];

  always_comb begin
    entry.command     = in_ch.command;
    entry.frame_count = in_ch.frame_count;
    entry.silent      = in_ch.silent;
    entry.sample      = decode(cfg.sample_format, in_ch.sample_word);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !do_pop) count_r <= count_r + 1'b1;
      else if (!push && do_pop) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ----- rtl/pdr_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module pdr_div
  import pdr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  pdr_div_req_t  req,
  output pdr_div_rsp_t  rsp
);

  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem_r, num_r[DIV_NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        cnt_r  <= DIV_CNT_W'(DIV_NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
        num_r <= {num_r[DIV_NUM_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/pdr_back.sv -----
// Back end: packet state, downmix, peak scaling and frame emission.
module pdr_back
  import pdr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  pdr_cfg_t      cfg,
  input  logic          q_empty,
  input  pdr_entry_t    head,
  output logic          q_pop,
  output pdr_div_req_t  div_req,
  input  pdr_div_rsp_t  div_rsp,
  pdr_out_if.source     out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_OUT, S_DISP, S_HDIV, S_HERR, S_PEAK, S_DL, S_DR, S_FIN
  } state_t;

  localparam logic [18:0] PH_STEP = 19'(2 * OUTPUT_RATE);
  localparam logic [29:0] FULL    = 30'(8388608);

  state_t             state_r;
  pdr_entry_t         ent_r;
  logic [3:0]         chpos_r;
  logic signed [29:0] left_r;
  logic signed [29:0] right_r;
  logic [13:0]        si_r;
  logic [13:0]        plen_r;
  logic [11:0]        oi_r;
  logic [11:0]        ot_r;
  logic [14:0]        ph_q_r;
  logic [18:0]        ph_rem_r;
  logic               silence_r;
  logic               drop_r;
  logic [13:0]        j_r;
  logic               pre_r;
  logic [3:0]         n_r;
  logic [29:0]        peak_r;
  pdr_div_req_t       div_req_r;
  logic               ov_r;
  logic signed [23:0] ol_r;
  logic signed [23:0] or_r;
  logic               olast_r;
  logic               ostat_r;

  logic signed [17:0] w;
  logic               to_l;
  logic               to_r;
  logic signed [42:0] prod;
  logic signed [29:0] term;
  logic signed [29:0] base_l;
  logic signed [29:0] base_r;
  logic signed [29:0] sum_l;
  logic signed [29:0] sum_r;
  logic [4:0]         chpos_inc;
  logic [29:0]        abs_l;
  logic [29:0]        abs_r;
  logic [29:0]        peak;
  logic [14:0]        src;
  logic [13:0]        plen_m1;
  logic               handshake;
  logic               owed;

  function automatic logic signed [23:0] sat24(input logic signed [29:0] x);
    if (x > 30'sd8388607) sat24 = 24'sh7FFFFF;
    else if (x < -30'sd8388608) sat24 = 24'sh800000;
    else sat24 = x[23:0];
  endfunction

  function automatic logic signed [29:0] scaled(input logic signed [29:0] x,
                                                 input logic [DIV_NUM_W-1:0] q);
    logic [29:0] m;
    begin
      m = (q > DIV_NUM_W'(FULL)) ? FULL : q[29:0];
      scaled = x[29] ? -$signed(m) : $signed(m);
    end
  endfunction

  assign q_pop      = (state_r == S_IDLE) && !q_empty;
  assign div_req    = div_req_r;
  assign handshake  = ov_r && out_ch.ready;
  assign out_ch.valid      = ov_r;
  assign out_ch.left_out   = ol_r;
  assign out_ch.right_out  = or_r;
  assign out_ch.last_frame = olast_r;
  assign out_ch.status     = ostat_r;

  always_comb begin
    w    = 18'sd65536;
    to_l = 1'b0;
    to_r = 1'b0;
    case (chpos_r)
      4'd0: to_l = 1'b1;
      4'd1: to_r = 1'b1;
      4'd2: begin w = 18'sd46341; to_l = 1'b1; to_r = 1'b1; end
      4'd3: begin w = 18'sd32768; to_l = 1'b1; to_r = 1'b1; end
      4'd4, 4'd6: begin w = 18'sd46341; to_l = 1'b1; end
      4'd5, 4'd7: begin w = 18'sd46341; to_r = 1'b1; end
      default: begin
        w    = 18'sd32768;
        to_l = !chpos_r[0];
        to_r = chpos_r[0];
      end
    endcase
  end

  assign prod      = ent_r.sample * w;
  assign term      = 30'((prod + 43'sd32768) >>> 16);
  assign base_l    = (chpos_r == 4'd0) ? '0 : left_r;
  assign base_r    = (chpos_r == 4'd0) ? '0 : right_r;
  assign sum_l     = to_l ? base_l + term : base_l;
  assign sum_r     = to_r ? base_r + term : base_r;
  assign chpos_inc = {1'b0, chpos_r} + 5'd1;
  assign abs_l     = left_r[29] ? 30'(-left_r) : left_r;
  assign abs_r     = right_r[29] ? 30'(-right_r) : right_r;
  assign peak      = (abs_l > abs_r) ? abs_l : abs_r;
  assign plen_m1   = plen_r - 14'd1;
  assign src       = (ph_q_r > {1'b0, plen_m1}) ? {1'b0, plen_m1} : ph_q_r;
  assign owed      = !drop_r && plen_r != '0 && si_r >= plen_r && oi_r < ot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      chpos_r   <= '0;
      left_r    <= '0;
      right_r   <= '0;
      si_r      <= '0;
      plen_r    <= '0;
      oi_r      <= '0;
      ot_r      <= '0;
      ph_q_r    <= '0;
      ph_rem_r  <= '0;
      silence_r <= 1'b0;
      drop_r    <= 1'b1;
      pre_r     <= 1'b0;
      n_r       <= '0;
      ov_r      <= 1'b0;
      div_req_r <= '0;
    end else begin
      div_req_r.start <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            ent_r <= head;
            n_r   <= '0;
            if (owed) begin
              j_r     <= plen_m1;
              pre_r   <= 1'b1;
              state_r <= S_CHK;
            end else begin
              state_r <= S_DISP;
            end
          end
        end
        S_CHK: begin
          if (n_r < 4'(RESULT_LIMIT) && oi_r < ot_r) begin
            if (ph_rem_r >= PH_STEP) begin
              ph_rem_r <= ph_rem_r - PH_STEP;
              ph_q_r   <= ph_q_r + 15'd1;
            end else if (src > {1'b0, j_r}) begin
              state_r <= pre_r ? S_DISP : S_IDLE;
            end else begin
              ov_r    <= 1'b1;
              ol_r    <= sat24(left_r);
              or_r    <= sat24(right_r);
              olast_r <= (oi_r + 12'd1 == ot_r);
              ostat_r <= 1'b0;
              state_r <= S_OUT;
            end
          end else begin
            state_r <= pre_r ? S_DISP : S_IDLE;
          end
        end
        S_OUT: begin
          if (handshake) begin
            ov_r     <= 1'b0;
            oi_r     <= oi_r + 12'd1;
            ph_rem_r <= ph_rem_r + {cfg.rate, 1'b0};
            n_r      <= n_r + 4'd1;
            state_r  <= S_CHK;
          end
        end
        S_DISP: begin
          pre_r <= 1'b0;
          if (ent_r.command == CMD_HEADER) begin
            chpos_r   <= '0;
            left_r    <= '0;
            right_r   <= '0;
            si_r      <= '0;
            oi_r      <= '0;
            ot_r      <= '0;
            ph_q_r    <= '0;
            ph_rem_r  <= 19'(OUTPUT_RATE);
            silence_r <= ent_r.silent;
            plen_r    <= ent_r.frame_count;
            if (ent_r.frame_count == '0) begin
              drop_r  <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              div_req_r.start <= 1'b1;
              div_req_r.num   <= DIV_NUM_W'(31'(ent_r.frame_count) * 31'(2 * OUTPUT_RATE)
                                            + 31'(cfg.rate));
              div_req_r.den   <= DIV_DEN_W'({cfg.rate, 1'b0});
              state_r         <= S_HDIV;
            end
          end else if (drop_r || si_r >= plen_r) begin
            state_r <= S_IDLE;
          end else begin
            if (cfg.channels == 5'd1) begin
              left_r  <= 30'(ent_r.sample);
              right_r <= 30'(ent_r.sample);
            end else begin
              left_r  <= sum_l;
              right_r <= sum_r;
            end
            if (chpos_inc < cfg.channels) begin
              chpos_r <= chpos_inc[3:0];
              state_r <= S_IDLE;
            end else begin
              chpos_r <= '0;
              state_r <= (cfg.channels > 5'd2) ? S_PEAK : S_FIN;
            end
          end
        end
        S_HDIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quo inside {52'd120, 52'd240, 52'd480, 52'd960, 52'd1920, 52'd2880}
                && div_rsp.quo <= DIV_NUM_W'(MAX_OUTPUT_FRAMES)) begin
              drop_r  <= 1'b0;
              ot_r    <= div_rsp.quo[11:0];
              state_r <= S_IDLE;
            end else begin
              drop_r  <= 1'b1;
              ov_r    <= 1'b1;
              ol_r    <= '0;
              or_r    <= '0;
              olast_r <= 1'b0;
              ostat_r <= 1'b1;
              state_r <= S_HERR;
            end
          end
        end
        S_HERR: begin
          if (handshake) begin
            ov_r    <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        S_PEAK: begin
          if (peak > FULL) begin
            peak_r          <= peak;
            div_req_r.start <= 1'b1;
            div_req_r.num   <= {abs_l[28:0], 23'd0} + DIV_NUM_W'(peak[29:1]);
            div_req_r.den   <= peak[28:0];
            state_r         <= S_DL;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DL: begin
          if (div_rsp.done) begin
            left_r          <= scaled(left_r, div_rsp.quo);
            div_req_r.start <= 1'b1;
            div_req_r.num   <= {abs_r[28:0], 23'd0} + DIV_NUM_W'(peak_r[29:1]);
            div_req_r.den   <= peak_r[28:0];
            state_r         <= S_DR;
          end
        end
        S_DR: begin
          if (div_rsp.done) begin
            right_r <= scaled(right_r, div_rsp.quo);
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (silence_r) begin
            left_r  <= '0;
            right_r <= '0;
          end
          j_r     <= si_r;
          si_r    <= si_r + 14'd1;
          pre_r   <= 1'b0;
          state_r <= S_CHK;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/pdr_checker.sv -----
// Port-level checks of the PCM downmix resampler and their binding.
module pdr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] left_out,
  input logic signed [23:0] right_out,
  input logic               last_frame,
  input logic               status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out)
      && $stable(last_frame) && $stable(status))
    else $error("result beat changed while stalled");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> left_out == 24'sd0 && right_out == 24'sd0 && !last_frame)
    else $error("error beat carries sample data");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pcm_downmix_resampler_unit pdr_checker u_pdr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .left_out   (out_ch.left_out),
  .right_out  (out_ch.right_out),
  .last_frame (out_ch.last_frame),
  .status     (out_ch.status)
);
